// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the splitter RTL files.
// No dependencies; files that check themselves include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define DTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked check that holds through reset as well.
`define DTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/dts_pkg.sv =====
// Shared types and constants of the delimiter token splitter.
// No dependencies; dts_front, dts_back and the top level import it.
`default_nettype none

package dts_pkg;

  localparam int DTS_MAX_DELIM_BYTES = 8;
  localparam int DTS_OFFSET_BITS     = 16;

  localparam int DTS_BYTE_W   = 8;
  localparam int DTS_DELIM_W  = 64;
  localparam int DTS_LEN_W    = 4;
  localparam int DTS_LIMIT_W  = 16;
  localparam int DTS_FIELD_W  = 16;
  localparam int DTS_CFG_IDX_W = 2;

  typedef enum logic [DTS_CFG_IDX_W-1:0] {
    CFG_DELIM_BYTES = 2'd0,
    CFG_DELIM_LEN   = 2'd1,
    CFG_TOKEN_LIMIT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic present;
    logic last;
    logic ovf;
  } dts_flags_t;

  // Queue record: start (offset_bits+1), length (offset_bits+2), flags.
  function automatic int dts_rec_w(input int offset_bits);
    return 2 * offset_bits + 3 + $bits(dts_flags_t);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dts_front.sv =====
// Front end: config registers, byte window, delimiter compare, token state.
// Depends on dts_pkg; pushes one record per reported token into the queue.
`default_nettype none
`include "assert_macros.svh"

module dts_front import dts_pkg::*; #(
  parameter int MAX_DELIM_BYTES = DTS_MAX_DELIM_BYTES,
  parameter int OFFSET_BITS     = DTS_OFFSET_BITS,
  parameter int REC_W           = dts_rec_w(OFFSET_BITS)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [DTS_CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DTS_DELIM_W-1:0]   cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [DTS_BYTE_W-1:0]    source_byte_i,
  input  wire logic                     source_end_i,
  output logic                          push_valid_o,
  input  wire logic                     push_ready_i,
  output logic [REC_W-1:0]              push_data_o
);

  localparam int PW = OFFSET_BITS + 1;
  localparam int LW = OFFSET_BITS + 2;

  typedef struct packed {
    logic [PW-1:0] start;
    logic [LW-1:0] len;
    dts_flags_t    flags;
  } rec_t;

  logic [DTS_DELIM_W-1:0] delim_q;
  logic [DTS_LEN_W-1:0]   dlen_q;
  logic [DTS_LIMIT_W-1:0] limit_q;

  logic [DTS_BYTE_W-1:0]  win_q [MAX_DELIM_BYTES];
  logic [DTS_BYTE_W-1:0]  win_d [MAX_DELIM_BYTES];
  logic [PW-1:0]          pos_q, pos_d;
  logic [PW-1:0]          cts_q;
  logic [DTS_LIMIT_W-1:0] tok_q;
  logic                   ovf_q, ovf_d;
  logic [DTS_LEN_W-1:0]   fresh_q, fresh_d;

  logic [MAX_DELIM_BYTES-1:0] tap_ok;
  logic                       acc, enabled, limited, match, nonempty;
  logic [LW-1:0]              pos_p1, len_ext, cts_ext, mstart, tl_m, tl_e;
  rec_t                       rec;
  logic                       rec_valid;

  assign in_ready_o = push_ready_i;
  assign acc        = in_valid_i && in_ready_o;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= '0;
      dlen_q  <= DTS_LEN_W'(1);
      limit_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DELIM_BYTES: delim_q <= cfg_wdata_i;
        CFG_DELIM_LEN:   dlen_q  <= cfg_wdata_i[DTS_LEN_W-1:0];
        CFG_TOKEN_LIMIT: limit_q <= cfg_wdata_i[DTS_LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Window after shifting in the new byte; tap 0 is the newest.
  always_comb begin
    win_d[0] = source_byte_i;
    for (int j = 1; j < MAX_DELIM_BYTES; j++) begin
      win_d[j] = win_q[j-1];
    end
  end

  // Tap j holds delimiter byte dlen-1-j when j is inside the delimiter.
  always_comb begin
    for (int j = 0; j < MAX_DELIM_BYTES; j++) begin
      logic [2:0] k;
      k = 3'(dlen_q - DTS_LEN_W'(j) - DTS_LEN_W'(1));
      tap_ok[j] = (DTS_LEN_W'(j) >= dlen_q) ||
                  (win_d[j] == delim_q[{k, 3'b000} +: DTS_BYTE_W]);
    end
  end

  always_comb begin
    fresh_d  = (fresh_q <= DTS_LEN_W'(MAX_DELIM_BYTES)) ? fresh_q + DTS_LEN_W'(1) : fresh_q;
    ovf_d    = ovf_q | pos_q[OFFSET_BITS];
    enabled  = (dlen_q != '0) && (dlen_q <= DTS_LEN_W'(MAX_DELIM_BYTES));
    limited  = (limit_q != '0) &&
               (({1'b0, tok_q} + (DTS_LIMIT_W+1)'(1)) >= {1'b0, limit_q});
    match    = enabled && !limited && (fresh_d >= dlen_q) && (&tap_ok);
    nonempty = fresh_d > dlen_q;

    pos_p1  = {1'b0, pos_q} + LW'(1);
    len_ext = LW'(dlen_q);
    cts_ext = {1'b0, cts_q};
    mstart  = (pos_p1 >= len_ext) ? pos_p1 - len_ext : '0;
    tl_m    = (mstart >= cts_ext) ? mstart - cts_ext : '0;
    tl_e    = (pos_q >= cts_q) ? pos_p1 - cts_ext : '0;
    // Hold the position once it passes the offset range.
    pos_d   = pos_q[OFFSET_BITS] ? pos_q : pos_p1[PW-1:0];

    rec.start         = cts_q;
    rec.len           = tl_m;
    rec.flags.present = 1'b1;
    rec.flags.last    = source_end_i;
    rec.flags.ovf     = ovf_d;
    rec_valid         = match && nonempty;
    if (source_end_i) begin
      rec_valid = 1'b1;
      if (match) begin
        if (!nonempty) begin
          rec.start         = '0;
          rec.len           = '0;
          rec.flags.present = 1'b0;
        end
      end else begin
        rec.len = tl_e;
      end
    end
  end

  assign push_valid_o = acc && rec_valid;
  assign push_data_o  = rec;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      for (int j = 0; j < MAX_DELIM_BYTES; j++) begin
        win_q[j] <= win_d[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      cts_q   <= '0;
      tok_q   <= '0;
      ovf_q   <= 1'b0;
      fresh_q <= '0;
    end else if (acc) begin
      if (source_end_i) begin
        pos_q   <= '0;
        cts_q   <= '0;
        tok_q   <= '0;
        ovf_q   <= 1'b0;
        fresh_q <= '0;
      end else begin
        pos_q <= pos_d;
        ovf_q <= ovf_d;
        if (match) begin
          if (nonempty && (tok_q != '1)) begin
            tok_q <= tok_q + DTS_LIMIT_W'(1);
          end
          cts_q   <= pos_d;
          fresh_q <= '0;
        end else begin
          fresh_q <= fresh_d;
        end
      end
    end
  end

  `DTS_ASSERT(a_end_clears, (acc && source_end_i) |=> (pos_q == '0 && fresh_q == '0 && tok_q == '0), "stream state not cleared after final byte")
  `DTS_ASSERT(a_pos_step, (acc && !source_end_i && !pos_q[OFFSET_BITS]) |=> (pos_q == $past(pos_q) + PW'(1)), "byte position did not advance")
  `DTS_ASSERT(a_fresh_bound, fresh_q <= DTS_LEN_W'(MAX_DELIM_BYTES + 1), "fresh byte count out of range")

endmodule

`default_nettype wire

// ===== hdl/dts_queue.sv =====
// Two-entry queue between the splitter front end and the output stage.
// Depends on assert_macros.svh; record width comes from the parent.
`default_nettype none
`include "assert_macros.svh"

module dts_queue #(
  parameter int W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_valid_i,
  output logic              push_ready_o,
  input  wire logic [W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  wire logic         pop_ready_i,
  output logic [W-1:0]      pop_data_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_q, rd_q;
  logic [1:0]   cnt_q;
  logic         push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  `DTS_ASSERT(a_no_push_full, push_valid_i |-> (cnt_q != 2'd2), "request pushed into full queue")
  `DTS_ASSERT(a_fill_count, (push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1), "queue count did not grow")

endmodule

`default_nettype wire

// ===== hdl/dts_back.sv =====
// Output stage: saturates queued offsets and lengths into result fields.
// Depends on dts_pkg; holds one result until the receiver takes it.
`default_nettype none

module dts_back import dts_pkg::*; #(
  parameter int OFFSET_BITS = DTS_OFFSET_BITS,
  parameter int REC_W       = dts_rec_w(OFFSET_BITS)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   pop_valid_i,
  output logic                        pop_ready_o,
  input  wire logic [REC_W-1:0]       pop_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [DTS_FIELD_W-1:0]      token_start_o,
  output logic [DTS_FIELD_W-1:0]      token_length_o,
  output logic                        token_present_o,
  output logic                        end_of_source_o,
  output logic                        position_overflow_o
);

  localparam int PW = OFFSET_BITS + 1;
  localparam int LW = OFFSET_BITS + 2;

  typedef struct packed {
    logic [PW-1:0] start;
    logic [LW-1:0] len;
    dts_flags_t    flags;
  } rec_t;

  rec_t                   rec;
  logic [OFFSET_BITS-1:0] start_sat, len_sat;
  logic                   valid_q;
  logic [DTS_FIELD_W-1:0] start_q, len_q;
  dts_flags_t             flags_q;
  logic                   pop;

  assign rec         = rec_t'(pop_data_i);
  assign pop_ready_o = !valid_q || out_ready_i;
  assign pop         = pop_valid_i && pop_ready_o;

  // Clamp to the top offset before narrowing to the result width.
  assign start_sat = rec.start[OFFSET_BITS] ? '1 : rec.start[OFFSET_BITS-1:0];
  assign len_sat   = (|rec.len[LW-1:OFFSET_BITS]) ? '1 : rec.len[OFFSET_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_ready_o) begin
      valid_q <= pop_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      start_q <= DTS_FIELD_W'(start_sat);
      len_q   <= DTS_FIELD_W'(len_sat);
      flags_q <= rec.flags;
    end
  end

  assign out_valid_o         = valid_q;
  assign token_start_o       = start_q;
  assign token_length_o      = len_q;
  assign token_present_o     = flags_q.present;
  assign end_of_source_o     = flags_q.last;
  assign position_overflow_o = flags_q.ovf;

endmodule

`default_nettype wire

// ===== hdl/delimiter_token_splitter_top.sv =====
// Delimiter token splitter, top level.
// Byte input channel, token result channel, and a plain config write port.
// Source bytes arrive one per request on source_byte_i, with source_end_i
// high on the final byte. Each request is accepted when in_valid_i and
// in_ready_o are both high; one byte can be accepted every cycle while the queue has room.
// A token ending at a delimiter produces one result request on the output
// channel (out_valid_o/out_ready_i) with its start offset and length; the
// final byte always produces one result with end_of_source_o high, and
// token_present_o low when no token is left. Other bytes produce nothing.
// The compare logic writes the queue when it accepts the byte; the output
// register then loads the result from the queue once it is free to take it.
// Throughput is one byte per cycle while the receiver keeps up.
// When the receiver stalls, results collect in the queue and the output
// register; in_ready_o drops once the queue holds two results.
// Reset clears the stream state and loads the register defaults: delimiter
// bytes 0, delimiter length 1, token limit 0 (unlimited). Registers are
// written by cfg_we_i with cfg_idx_i 0, 1, 2; the user must write them only while the block is idle (unenforced).
`default_nettype none

module delimiter_token_splitter_top import dts_pkg::*; #(
  parameter int MAX_DELIM_BYTES = DTS_MAX_DELIM_BYTES,
  parameter int OFFSET_BITS     = DTS_OFFSET_BITS
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [DTS_CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DTS_DELIM_W-1:0]   cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [DTS_BYTE_W-1:0]    source_byte_i,
  input  wire logic                     source_end_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [DTS_FIELD_W-1:0]        token_start_o,
  output logic [DTS_FIELD_W-1:0]        token_length_o,
  output logic                          token_present_o,
  output logic                          end_of_source_o,
  output logic                          position_overflow_o
);

  localparam int REC_W = dts_rec_w(OFFSET_BITS);

  logic             push_valid, push_ready;
  logic [REC_W-1:0] push_data;
  logic             pop_valid, pop_ready;
  logic [REC_W-1:0] pop_data;

  dts_front #(
    .MAX_DELIM_BYTES (MAX_DELIM_BYTES),
    .OFFSET_BITS     (OFFSET_BITS),
    .REC_W           (REC_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .source_byte_i (source_byte_i),
    .source_end_i  (source_end_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_data_o   (push_data)
  );

  dts_queue #(
    .W (REC_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  dts_back #(
    .OFFSET_BITS (OFFSET_BITS),
    .REC_W       (REC_W)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .pop_valid_i         (pop_valid),
    .pop_ready_o         (pop_ready),
    .pop_data_i          (pop_data),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .token_start_o       (token_start_o),
    .token_length_o      (token_length_o),
    .token_present_o     (token_present_o),
    .end_of_source_o     (end_of_source_o),
    .position_overflow_o (position_overflow_o)
  );

endmodule

`default_nettype wire
